// ===== rtl/core/cosine_similarity_match_table_core_assert.svh =====
// Assertion macros used by the core module.
`ifndef COSINE_SIMILARITY_MATCH_TABLE_CORE_ASSERT_SVH
`define COSINE_SIMILARITY_MATCH_TABLE_CORE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define CSSM_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("core assertion failed");

// Next-cycle implication, checked outside reset.
`define CSSM_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("core assertion failed");

`endif

// ===== rtl/core/cssm_pkg.sv =====
`default_nettype none
package cssm_pkg;

   localparam int MAX_ENTRIES = 64;
   localparam int MAX_LENGTH  = 512;
   localparam int ELEM_W      = 16;
   localparam int FEAT_W      = 16;
   localparam int TAG_W       = 32;
   localparam int STAMP_W     = 32;
   localparam int LEN_W       = 10;
   localparam int SCORE_W     = 15;

   localparam int SLOT_W  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int IDX_W   = (MAX_LENGTH > 1) ? $clog2(MAX_LENGTH) : 1;
   localparam int CNT_W   = $clog2(MAX_LENGTH + 2);
   localparam int VA_W    = ((MAX_ENTRIES * MAX_LENGTH) > 1) ?
                            $clog2(MAX_ENTRIES * MAX_LENGTH) : 1;
   localparam int NORM_W  = 2 * ELEM_W - 1 + ((MAX_LENGTH > 1) ? $clog2(MAX_LENGTH) : 1);
   localparam int DOT_W   = NORM_W + 1;
   localparam int PROD_W  = 2 * ELEM_W;
   localparam int INFO_W  = TAG_W + STAMP_W + NORM_W;
   localparam int MCNT_W  = $clog2(NORM_W);
   localparam int ROOT_W  = 2 * NORM_W + 2 * SCORE_W + 1;
   localparam int BIT_W   = $clog2(SCORE_W);

   localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(512);

   typedef enum logic [1:0] {
      CMD_INSERT = 2'd0,
      CMD_SEARCH = 2'd1,
      CMD_REMOVE = 2'd2,
      CMD_NOP    = 2'd3
   } cmd_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SCAN_RD,
      ST_SCAN_CK,
      ST_COPY,
      ST_INS_FIN,
      ST_NQ,
      ST_SLOT,
      ST_DOT,
      ST_SC_START,
      ST_SC_WAIT,
      ST_RESP
   } core_state_type;

   typedef enum logic [2:0] {
      SC_IDLE,
      SC_MUL,
      SC_ROOT_A,
      SC_ROOT_B,
      SC_DONE
   } score_state_type;

endpackage
`default_nettype wire

// ===== rtl/core/cssm_ram.sv =====
`default_nettype none
module cssm_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 512
) (
   input  wire logic                             clock,
   input  wire logic                             we,
   input  wire logic [$clog2(DEPTH)-1:0]         waddr,
   input  wire logic [WIDTH-1:0]                 wdata,
   input  wire logic [$clog2(DEPTH)-1:0]         raddr,
   output logic      [WIDTH-1:0]                 rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule
`default_nettype wire

// ===== rtl/core/cssm_score.sv =====
`default_nettype none
module cssm_score (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               start,
   input  wire logic signed [cssm_pkg::DOT_W-1:0]  dot,
   input  wire logic [cssm_pkg::NORM_W-1:0]        norm_q,
   input  wire logic [cssm_pkg::NORM_W-1:0]        norm_s,
   output logic                                    done,
   output logic [cssm_pkg::SCORE_W-1:0]            score
);
   import cssm_pkg::*;

   score_state_type st_ff, st_in;
   logic [2*NORM_W-1:0] mcand_ff, mcand_in, macc_ff, macc_in, p_ff, p_in;
   logic [NORM_W-1:0]   mplier_ff, mplier_in, dmag_ff, dmag_in;
   logic [MCNT_W-1:0]   k_ff, k_in;
   logic                phase_ff, phase_in;
   logic [ROOT_W-1:0]   r_ff, r_in, t_ff, t_in, ush_ff, ush_in, p2_ff, p2_in;
   logic [ROOT_W-1:0]   cand_ff, cand_in, ush_new;
   logic [SCORE_W-1:0]  s_ff, s_in;
   logic [BIT_W-1:0]    b_ff, b_in;
   logic                trivial, mul_last, fits;

   assign trivial  = dot[DOT_W-1] || (dot == '0) || (norm_q == '0) || (norm_s == '0);
   assign mul_last = (k_ff == MCNT_W'(NORM_W - 1));
   assign fits     = (cand_ff <= r_ff);
   assign macc_in  = macc_ff + (mplier_ff[0] ? mcand_ff : '0);
   assign ush_new  = fits ? (ush_ff + (p2_ff << 1)) : ush_ff;

   // next state
   always_comb begin
      st_in = st_ff;
      unique case (st_ff)
         SC_IDLE:   if (start) st_in = trivial ? SC_DONE : SC_MUL;
         SC_MUL:    if (mul_last && phase_ff) st_in = SC_ROOT_A;
         SC_ROOT_A: st_in = SC_ROOT_B;
         SC_ROOT_B: st_in = (b_ff == '0) ? SC_DONE : SC_ROOT_A;
         SC_DONE:   st_in = SC_IDLE;
         default:   st_in = SC_IDLE;
      endcase
   end

   // datapath: shift-add products, then the root found one bit at a time
   always_comb begin
      mcand_in  = mcand_ff;
      mplier_in = mplier_ff;
      dmag_in   = dmag_ff;
      k_in      = k_ff;
      phase_in  = phase_ff;
      p_in      = p_ff;
      r_in      = r_ff;
      t_in      = t_ff;
      ush_in    = ush_ff;
      p2_in     = p2_ff;
      cand_in   = cand_ff;
      s_in      = s_ff;
      b_in      = b_ff;
      unique case (st_ff)
         SC_IDLE: begin
            s_in      = '0;
            dmag_in   = dot[NORM_W-1:0];
            mcand_in  = (2*NORM_W)'(norm_q);
            mplier_in = norm_s;
            k_in      = '0;
            phase_in  = 1'b0;
         end
         SC_MUL: begin
            mcand_in  = mcand_ff << 1;
            mplier_in = mplier_ff >> 1;
            k_in      = k_ff + MCNT_W'(1);
            if (mul_last) begin
               k_in = '0;
               if (!phase_ff) begin
                  p_in      = macc_in;
                  mcand_in  = (2*NORM_W)'(dmag_ff);
                  mplier_in = dmag_ff;
                  phase_in  = 1'b1;
               end else begin
                  r_in   = ROOT_W'(macc_in) << (2 * SCORE_W);
                  t_in   = '0;
                  ush_in = '0;
                  p2_in  = ROOT_W'(p_ff) << (2 * (SCORE_W - 1));
                  s_in   = '0;
                  b_in   = BIT_W'(SCORE_W - 1);
               end
            end
         end
         SC_ROOT_A: cand_in = t_ff + ush_ff + p2_ff;
         SC_ROOT_B: begin
            if (fits) begin
               t_in = cand_ff;
               s_in = s_ff | (SCORE_W'(1) << b_ff);
            end
            if (b_ff != '0) begin
               ush_in = ush_new >> 1;
               p2_in  = p2_ff >> 2;
               b_in   = b_ff - BIT_W'(1);
            end
         end
         SC_DONE: ;
         default: ;
      endcase
   end

   // accumulator of the multiplier clears between products
   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= SC_IDLE;
      end else begin
         st_ff <= st_in;
      end
      macc_ff   <= (st_ff == SC_MUL && !mul_last) ? macc_in : '0;
      mcand_ff  <= mcand_in;
      mplier_ff <= mplier_in;
      dmag_ff   <= dmag_in;
      k_ff      <= k_in;
      phase_ff  <= phase_in;
      p_ff      <= p_in;
      r_ff      <= r_in;
      t_ff      <= t_in;
      ush_ff    <= ush_in;
      p2_ff     <= p2_in;
      cand_ff   <= cand_in;
      s_ff      <= s_in;
      b_ff      <= b_in;
   end

   assign done  = (st_ff == SC_DONE);
   assign score = s_ff;

endmodule
`default_nettype wire

// ===== rtl/core/cosine_similarity_match_table_core.sv =====
// Channel | Ports                                   | Handshake
// request | req_cmd, req_entry_tag, req_feature_value | start && !busy
// result  | rsp_status, rsp_match_found, rsp_best_*  | rsp_strobe, one cycle
// config  | csr_write_data                          | csr_write_enable
//
// An element that does not end a stream gives no result word.
// Remove scans the slot table, reading and then checking each slot.
// Insert scans, then copies MAX_LENGTH elements into the vector memory
// through its single write port.
// Search: the query norm first, then per valid slot a dot product and
// the score unit (two shift-add products, then the root found one score
// bit at a time); an empty slot is skipped.
// Reset is synchronous; memories are not cleared, valid bits are.
// The result receiver never stalls.
`default_nettype none
`include "cosine_similarity_match_table_core_assert.svh"
module cosine_similarity_match_table_core (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                start,
   output logic                                     busy,
   input  wire logic [1:0]                          req_cmd,
   input  wire logic [cssm_pkg::TAG_W-1:0]          req_entry_tag,
   input  wire logic signed [cssm_pkg::FEAT_W-1:0]  req_feature_value,
   input  wire logic                                csr_write_enable,
   input  wire logic [cssm_pkg::LEN_W-1:0]          csr_write_data,
   output logic                                     rsp_strobe,
   output logic                                     rsp_status,
   output logic                                     rsp_match_found,
   output logic [cssm_pkg::TAG_W-1:0]               rsp_best_tag,
   output logic [cssm_pkg::SCORE_W-1:0]             rsp_best_score
);
   import cssm_pkg::*;

   core_state_type state_ff, state_in;
   cmd_type cmd, op_ff, op_in;

   logic [LEN_W-1:0]       len_cfg_ff;
   logic [CNT_W-1:0]       count_ff, count_in, cnt_ff, cnt_in, len_eff, lim, idx;
   logic [TAG_W-1:0]       tag_ff, tag_in, best_tag_ff, best_tag_in;
   logic [SLOT_W-1:0]      slot_ff, slot_in, free_slot_ff, free_slot_in;
   logic                   free_found_ff, free_found_in;
   logic signed [DOT_W-1:0]  acc_ff, acc_in;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic [NORM_W-1:0]      nq_ff, nq_in;
   logic [MAX_ENTRIES-1:0] valid_ff, valid_in;
   logic [STAMP_W-1:0]     stamp_ff, stamp_in, best_stamp_ff, best_stamp_in;
   logic                   status_ff, status_in, best_found_ff, best_found_in;
   logic [SCORE_W-1:0]     best_score_ff, best_score_in;

   logic                   accept, stream_end, last_slot, hit, free_now;
   logic                   dstage, astage, fin, run;
   logic signed [ELEM_W-1:0] q_rdata, v_rdata, elem_a, elem_b;
   logic                   q_we, v_we, info_we, sc_start, sc_done;
   logic [IDX_W-1:0]       q_waddr, q_raddr;
   logic [VA_W-1:0]        v_waddr, v_raddr;
   logic [INFO_W-1:0]      info_rdata, info_wdata;
   logic [TAG_W-1:0]       info_tag;
   logic [STAMP_W-1:0]     info_stamp;
   logic [NORM_W-1:0]      info_norm;
   logic [SCORE_W-1:0]     sc_score;
   logic                   better;

   assign cmd    = cmd_type'(req_cmd);
   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;

   // effective vector length
   always_comb begin
      if (len_cfg_ff == '0) begin
         len_eff = CNT_W'(1);
      end else if (32'(len_cfg_ff) > MAX_LENGTH) begin
         len_eff = CNT_W'(MAX_LENGTH);
      end else begin
         len_eff = CNT_W'(len_cfg_ff);
      end
   end

   assign stream_end = ((CNT_W+1)'(count_ff) + (CNT_W+1)'(1)) >= (CNT_W+1)'(len_eff);
   assign last_slot  = (slot_ff == SLOT_W'(MAX_ENTRIES - 1));

   // slot record: tag, stamp, squared norm
   assign info_tag   = info_rdata[INFO_W-1 -: TAG_W];
   assign info_stamp = info_rdata[NORM_W +: STAMP_W];
   assign info_norm  = info_rdata[NORM_W-1:0];
   assign hit        = valid_ff[slot_ff] && (info_tag == tag_ff);
   assign free_now   = !valid_ff[slot_ff];

   // element pipeline: read, multiply, accumulate
   assign run    = (state_ff == ST_COPY) || (state_ff == ST_NQ) || (state_ff == ST_DOT);
   assign lim    = (state_ff == ST_COPY) ? CNT_W'(MAX_LENGTH) : len_eff;
   assign dstage = (cnt_ff != '0) && (cnt_ff <= lim);
   assign astage = cnt_ff >= CNT_W'(2);
   assign fin    = (cnt_ff == lim + CNT_W'(1));
   assign idx    = cnt_ff - CNT_W'(1);
   assign elem_a = (state_ff == ST_COPY && idx >= len_eff) ? '0 : q_rdata;
   assign elem_b = (state_ff == ST_DOT) ? v_rdata : elem_a;
   assign prod_in = PROD_W'(elem_a) * PROD_W'(elem_b);

   assign q_we    = accept && (cmd == CMD_INSERT || cmd == CMD_SEARCH);
   assign q_waddr = count_ff[IDX_W-1:0];
   assign q_raddr = cnt_ff[IDX_W-1:0];
   assign v_we    = (state_ff == ST_COPY) && dstage;
   assign v_waddr = VA_W'(slot_ff) * VA_W'(MAX_LENGTH) + VA_W'(idx[IDX_W-1:0]);
   assign v_raddr = VA_W'(slot_ff) * VA_W'(MAX_LENGTH) + VA_W'(cnt_ff[IDX_W-1:0]);
   assign info_we    = (state_ff == ST_INS_FIN);
   assign info_wdata = {tag_ff, stamp_ff, acc_ff[NORM_W-1:0]};
   assign sc_start   = (state_ff == ST_SC_START);

   assign better = (sc_score != '0) && (!best_found_ff || sc_score > best_score_ff ||
                   (sc_score == best_score_ff && info_stamp < best_stamp_ff));

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (cmd)
                  CMD_REMOVE: state_in = ST_SCAN_RD;
                  CMD_INSERT: if (stream_end) state_in = ST_SCAN_RD;
                  CMD_SEARCH: if (stream_end) state_in = ST_NQ;
                  CMD_NOP:    state_in = ST_IDLE;
               endcase
            end
         end
         ST_SCAN_RD: state_in = ST_SCAN_CK;
         ST_SCAN_CK: begin
            if (hit) begin
               state_in = (op_ff == CMD_REMOVE) ? ST_RESP : ST_COPY;
            end else if (last_slot) begin
               state_in = (op_ff != CMD_REMOVE && (free_found_ff || free_now)) ?
                          ST_COPY : ST_RESP;
            end else begin
               state_in = ST_SCAN_RD;
            end
         end
         ST_COPY:     if (fin) state_in = ST_INS_FIN;
         ST_INS_FIN:  state_in = ST_RESP;
         ST_NQ:       if (fin) state_in = ST_SLOT;
         ST_SLOT: begin
            if (valid_ff[slot_ff]) state_in = ST_DOT;
            else if (last_slot)    state_in = ST_RESP;
         end
         ST_DOT:      if (fin) state_in = ST_SC_START;
         ST_SC_START: state_in = ST_SC_WAIT;
         ST_SC_WAIT:  if (sc_done) state_in = last_slot ? ST_RESP : ST_SLOT;
         ST_RESP:     state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   // datapath updates
   always_comb begin
      op_in         = op_ff;
      count_in      = count_ff;
      tag_in        = tag_ff;
      slot_in       = slot_ff;
      free_slot_in  = free_slot_ff;
      free_found_in = free_found_ff;
      cnt_in        = '0;
      acc_in        = acc_ff;
      nq_in         = nq_ff;
      valid_in      = valid_ff;
      stamp_in      = stamp_ff;
      status_in     = status_ff;
      best_found_in = best_found_ff;
      best_tag_in   = best_tag_ff;
      best_stamp_in = best_stamp_ff;
      best_score_in = best_score_ff;
      if (run) begin
         cnt_in = fin ? '0 : cnt_ff + CNT_W'(1);
         if (cnt_ff == '0) acc_in = '0;
         else if (astage) acc_in = acc_ff + DOT_W'(prod_ff);
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && cmd != CMD_NOP) begin
               op_in         = cmd;
               tag_in        = req_entry_tag;
               slot_in       = '0;
               free_found_in = 1'b0;
               status_in     = 1'b0;
               best_found_in = 1'b0;
               best_tag_in   = '0;
               best_score_in = '0;
               if (cmd != CMD_REMOVE) begin
                  count_in = stream_end ? '0 : count_ff + CNT_W'(1);
               end
            end
         end
         ST_SCAN_CK: begin
            if (hit) begin
               if (op_ff == CMD_REMOVE) valid_in[slot_ff] = 1'b0;
            end else begin
               if (!free_found_ff && free_now) begin
                  free_found_in = 1'b1;
                  free_slot_in  = slot_ff;
               end
               if (last_slot) begin
                  if (free_found_ff) slot_in = free_slot_ff;
                  else if (!free_now && op_ff != CMD_REMOVE) status_in = 1'b1;
               end else begin
                  slot_in = slot_ff + SLOT_W'(1);
               end
            end
         end
         ST_INS_FIN: begin
            valid_in[slot_ff] = 1'b1;
            stamp_in          = stamp_ff + STAMP_W'(1);
         end
         ST_NQ: begin
            if (fin) begin
               nq_in   = acc_in[NORM_W-1:0];
               slot_in = '0;
            end
         end
         ST_SLOT: begin
            if (!valid_ff[slot_ff] && !last_slot) slot_in = slot_ff + SLOT_W'(1);
         end
         ST_SC_WAIT: begin
            if (sc_done) begin
               if (better) begin
                  best_found_in = 1'b1;
                  best_tag_in   = info_tag;
                  best_stamp_in = info_stamp;
                  best_score_in = sc_score;
               end
               if (!last_slot) slot_in = slot_ff + SLOT_W'(1);
            end
         end
         default: ;
      endcase
   end

   // registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         len_cfg_ff <= LEN_RESET;
         count_ff   <= '0;
         valid_ff   <= '0;
         stamp_ff   <= '0;
      end else begin
         state_ff <= state_in;
         if (csr_write_enable) len_cfg_ff <= csr_write_data;
         count_ff <= count_in;
         valid_ff <= valid_in;
         stamp_ff <= stamp_in;
      end
      op_ff         <= op_in;
      tag_ff        <= tag_in;
      slot_ff       <= slot_in;
      free_slot_ff  <= free_slot_in;
      free_found_ff <= free_found_in;
      cnt_ff        <= cnt_in;
      acc_ff        <= acc_in;
      prod_ff       <= prod_in;
      nq_ff         <= nq_in;
      status_ff     <= status_in;
      best_found_ff <= best_found_in;
      best_tag_ff   <= best_tag_in;
      best_stamp_ff <= best_stamp_in;
      best_score_ff <= best_score_in;
   end

   // result word
   assign rsp_strobe      = (state_ff == ST_RESP);
   assign rsp_status      = status_ff;
   assign rsp_match_found = best_found_ff;
   assign rsp_best_tag    = best_tag_ff;
   assign rsp_best_score  = best_score_ff;

   cssm_ram #(.WIDTH(ELEM_W), .DEPTH(MAX_LENGTH)) u_query_ram (
      .clock (clock),
      .we    (q_we),
      .waddr (q_waddr),
      .wdata (req_feature_value[ELEM_W-1:0]),
      .raddr (q_raddr),
      .rdata (q_rdata)
   );

   cssm_ram #(.WIDTH(ELEM_W), .DEPTH(MAX_ENTRIES * MAX_LENGTH)) u_vector_ram (
      .clock (clock),
      .we    (v_we),
      .waddr (v_waddr),
      .wdata (elem_a),
      .raddr (v_raddr),
      .rdata (v_rdata)
   );

   cssm_ram #(.WIDTH(INFO_W), .DEPTH(MAX_ENTRIES)) u_info_ram (
      .clock (clock),
      .we    (info_we),
      .waddr (slot_ff),
      .wdata (info_wdata),
      .raddr (slot_ff),
      .rdata (info_rdata)
   );

   cssm_score u_score (
      .clock  (clock),
      .reset  (reset),
      .start  (sc_start),
      .dot    (acc_ff),
      .norm_q (nq_ff),
      .norm_s (info_norm),
      .done   (sc_done),
      .score  (sc_score)
   );

   // checks
   `CSSM_ASSERT_NOW(a_strobe_busy, rsp_strobe, busy)
   `CSSM_ASSERT_NEXT(a_strobe_single, rsp_strobe, !rsp_strobe)
   `CSSM_ASSERT_NOW(a_full_no_match, rsp_strobe && rsp_status, !rsp_match_found)
   `CSSM_ASSERT_NOW(a_match_score, rsp_strobe && rsp_match_found, rsp_best_score != '0)

endmodule
`default_nettype wire

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;
   import cssm_pkg::*;

   // one pending request word or one length-register write
   typedef struct {
      bit                     is_len_write;
      cmd_type                cmd;
      logic [TAG_W-1:0]       tag;
      logic signed [FEAT_W-1:0] value;
      logic [LEN_W-1:0]       len;
   } pending_word_type;

   typedef struct {
      bit                     status;
      bit                     found;
      logic [TAG_W-1:0]       tag;
      logic [SCORE_W-1:0]     score;
   } match_word_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      start = 1'b0;
   logic                      busy;
   logic [1:0]                req_cmd = '0;
   logic [TAG_W-1:0]          req_entry_tag = '0;
   logic signed [FEAT_W-1:0]  req_feature_value = '0;
   logic                      csr_write_enable = 1'b0;
   logic [LEN_W-1:0]          csr_write_data = '0;
   logic                      rsp_strobe;
   logic                      rsp_status;
   logic                      rsp_match_found;
   logic [TAG_W-1:0]          rsp_best_tag;
   logic [SCORE_W-1:0]        rsp_best_score;

   pending_word_type          word_queue[$];
   match_word_type            match_queue[$];
   pending_word_type          in_flight;
   int                        failures = 0;
   int                        words_taken = 0;
   int                        quiet_cycles = 0;
   int                        stall_cycles = 0;

   // table mirror
   bit                        slot_used[MAX_ENTRIES];
   logic [TAG_W-1:0]          slot_tags[MAX_ENTRIES];
   logic [STAMP_W-1:0]        slot_stamps[MAX_ENTRIES];
   longint unsigned           slot_norms[MAX_ENTRIES];
   shortint                   slot_vectors[MAX_ENTRIES][MAX_LENGTH];
   shortint                   query_buf[MAX_LENGTH];
   int                        elem_count = 0;
   logic [STAMP_W-1:0]        next_stamp = '0;
   logic [LEN_W-1:0]          vec_len = LEN_RESET;

   // stimulus state
   shortint                   base_vectors[8][MAX_LENGTH];
   logic [TAG_W-1:0]          tag_pool[96];
   int                        gen_len = MAX_LENGTH;
   int                        random_words = 0;

   cosine_similarity_match_table_core i_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_cmd(req_cmd), .req_entry_tag(req_entry_tag),
      .req_feature_value(req_feature_value),
      .csr_write_enable(csr_write_enable), .csr_write_data(csr_write_data),
      .rsp_strobe(rsp_strobe), .rsp_status(rsp_status),
      .rsp_match_found(rsp_match_found), .rsp_best_tag(rsp_best_tag),
      .rsp_best_score(rsp_best_score)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic int active_len(logic [LEN_W-1:0] raw);
      if (raw == 0) return 1;
      if (raw > MAX_LENGTH) return MAX_LENGTH;
      return int'(raw);
   endfunction

   // largest s <= 32767 with s*s*nq*ns <= 2^30*dot*dot
   function automatic int unsigned cosine_q15(longint dot, longint unsigned nq,
                                              longint unsigned ns);
      bit [127:0]  rhs;
      bit [127:0]  prod;
      bit [127:0]  lhs;
      int unsigned lo;
      int unsigned hi;
      int unsigned mid;
      if (dot <= 0 || nq == 0 || ns == 0) return 0;
      rhs  = (128'(dot) * 128'(dot)) << 30;
      prod = 128'(nq) * 128'(ns);
      lo = 0;
      hi = 32767;
      while (lo < hi) begin
         mid = (lo + hi + 1) / 2;
         lhs = prod * 128'(mid) * 128'(mid);
         if (lhs <= rhs) lo = mid;
         else hi = mid - 1;
      end
      return lo;
   endfunction

   // advance the table mirror by one accepted word
   task automatic update_table(pending_word_type w);
      match_word_type   m;
      int               len;
      int               slot;
      int               best;
      int unsigned      best_s;
      int unsigned      s;
      longint           dot;
      longint unsigned  nq;
      m = '{0, 0, '0, '0};
      if (w.cmd == CMD_NOP) return;
      if (w.cmd == CMD_REMOVE) begin
         for (int i = 0; i < MAX_ENTRIES; i++)
            if (slot_used[i] && slot_tags[i] == w.tag) begin
               slot_used[i] = 0;
               break;
            end
         match_queue.insert(match_queue.size(), m);
         return;
      end
      len = active_len(vec_len);
      query_buf[elem_count] = w.value;
      if (elem_count + 1 < len) begin
         elem_count++;
         return;
      end
      elem_count = 0;
      if (w.cmd == CMD_INSERT) begin
         slot = -1;
         for (int i = 0; i < MAX_ENTRIES && slot < 0; i++)
            if (slot_used[i] && slot_tags[i] == w.tag) slot = i;
         for (int i = 0; i < MAX_ENTRIES && slot < 0; i++)
            if (!slot_used[i]) slot = i;
         if (slot < 0) m.status = 1;
         else begin
            slot_norms[slot] = 0;
            for (int j = 0; j < MAX_LENGTH; j++) begin
               slot_vectors[slot][j] = (j < len) ? query_buf[j] : 16'sd0;
               slot_norms[slot] += longint'(slot_vectors[slot][j]) *
                                   longint'(slot_vectors[slot][j]);
            end
            slot_tags[slot]   = w.tag;
            slot_stamps[slot] = next_stamp;
            slot_used[slot]   = 1;
            next_stamp++;
         end
      end else begin
         best = -1;
         best_s = 0;
         nq = 0;
         for (int j = 0; j < len; j++)
            nq += longint'(query_buf[j]) * longint'(query_buf[j]);
         for (int i = 0; i < MAX_ENTRIES; i++) begin
            if (!slot_used[i]) continue;
            dot = 0;
            for (int j = 0; j < len; j++)
               dot += longint'(query_buf[j]) * longint'(slot_vectors[i][j]);
            s = cosine_q15(dot, nq, slot_norms[i]);
            if (s == 0) continue;
            if (best < 0 || s > best_s ||
                (s == best_s && slot_stamps[i] < slot_stamps[best])) begin
               best = i;
               best_s = s;
            end
         end
         if (best >= 0) begin
            m.found = 1;
            m.tag   = slot_tags[best];
            m.score = best_s[SCORE_W-1:0];
         end
      end
      match_queue.insert(match_queue.size(), m);
   endtask

   // driver: request words and length writes
   always @(posedge clock) begin
      bit taken;
      bit start_next;
      bit write_next;
      if (reset) begin
         start <= 1'b0;
         csr_write_enable <= 1'b0;
         quiet_cycles = 0;
      end else begin
         taken = start && !busy;
         if (taken) begin
            update_table(in_flight);
            words_taken++;
         end
         start_next = start && !taken;
         write_next = 1'b0;
         if (match_queue.size() == 0 && !start && !busy) quiet_cycles++;
         else quiet_cycles = 0;
         if (!start_next && word_queue.size() > 0) begin
            if (word_queue[0].is_len_write) begin
               // only with the block drained
               if (quiet_cycles >= 8) begin
                  csr_write_data <= word_queue[0].len;
                  vec_len = word_queue[0].len;
                  write_next = 1'b1;
                  quiet_cycles = 0;
                  void'(word_queue.pop_front());
               end
            end else if ((words_taken > 1100 && words_taken < 1350) ||
                         $urandom_range(99) >= 27) begin
               in_flight = word_queue.pop_front();
               req_cmd <= in_flight.cmd;
               req_entry_tag <= in_flight.tag;
               req_feature_value <= in_flight.value;
               start_next = 1'b1;
            end
         end
         start <= start_next;
         csr_write_enable <= write_next;
      end
   end

   // monitor: compare each result word with the oldest prediction
   always @(posedge clock) begin
      match_word_type want;
      if (!reset && rsp_strobe) begin
         if (match_queue.size() == 0) begin
            failures++;
            $display("%0t unexpected result: status=%0d found=%0d tag=%h score=%0d",
                     $time, rsp_status, rsp_match_found, rsp_best_tag, rsp_best_score);
         end else begin
            want = match_queue.pop_front();
            if (rsp_status !== want.status || rsp_match_found !== want.found ||
                rsp_best_tag !== want.tag || rsp_best_score !== want.score) begin
               failures++;
               $display("%0t mismatch: expected status=%0d found=%0d tag=%h score=%0d",
                        $time, want.status, want.found, want.tag, want.score);
               $display("%0t            actual status=%0d found=%0d tag=%h score=%0d",
                        $time, rsp_status, rsp_match_found, rsp_best_tag,
                        rsp_best_score);
            end
         end
      end
   end

   // watchdog on cycles with no traffic
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= 300000) begin
         $display("tb: failure");
         $finish;
      end
   end

   task automatic push_word(cmd_type cmd, logic [TAG_W-1:0] tag, shortint value);
      pending_word_type w;
      w.is_len_write = 0;
      w.cmd = cmd;
      w.tag = tag;
      w.value = value;
      w.len = '0;
      word_queue.insert(word_queue.size(), w);
      if (cmd != CMD_NOP) random_words++;
   endtask

   task automatic push_len(logic [LEN_W-1:0] len);
      pending_word_type w;
      w = '{1, CMD_NOP, '0, '0, len};
      word_queue.insert(word_queue.size(), w);
      gen_len = active_len(len);
   endtask

   function automatic shortint pick_element(int mode, int base, int j);
      case (mode)
         0: return shortint'($urandom);
         1: return base_vectors[base][j];
         2: return ($urandom_range(3) == 0) ? shortint'($urandom) : base_vectors[base][j];
         default: begin
            case ($urandom_range(3))
               0: return -16'sd32768;
               1: return 16'sd32767;
               2: return 16'sd0;
               default: return shortint'($urandom_range(7)) - 16'sd3;
            endcase
         end
      endcase
   endfunction

   // one full stream; the final word's command and tag decide the action
   task automatic push_stream(cmd_type cmd, logic [TAG_W-1:0] tag);
      int      mode;
      int      base;
      cmd_type c;
      mode = $urandom_range(3);
      base = $urandom_range(7);
      for (int j = 0; j < gen_len; j++) begin
         c = cmd;
         if (j != gen_len - 1 && $urandom_range(4) == 0)
            c = $urandom_range(1) ? CMD_SEARCH : CMD_INSERT;
         push_word(c, (j == gen_len - 1) ? tag : $urandom, pick_element(mode, base, j));
      end
   endtask

   initial begin
      int lens[8];
      int phase_words;
      int r;
      lens = '{4, 2, 1, 6, 3, 0, 5, 4};
      for (int k = 0; k < 8; k++)
         for (int j = 0; j < MAX_LENGTH; j++)
            base_vectors[k][j] = shortint'($urandom);
      tag_pool[0] = '0;
      tag_pool[1] = '1;
      for (int k = 2; k < 96; k++) tag_pool[k] = $urandom;

      // full-length vectors: insert then search the same one
      push_len(10'd512);
      for (int j = 0; j < MAX_LENGTH; j++)
         push_word(CMD_INSERT, tag_pool[2], base_vectors[0][j]);
      for (int j = 0; j < MAX_LENGTH; j++)
         push_word(CMD_SEARCH, $urandom, base_vectors[0][j]);

      // one-element vectors: extremes, zero norm, no-op, removes
      push_len(10'd0);
      push_word(CMD_INSERT, tag_pool[0], 16'sd32767);
      push_word(CMD_INSERT, tag_pool[1], -16'sd32768);
      push_word(CMD_INSERT, tag_pool[3], 16'sd0);
      push_word(CMD_SEARCH, 32'h0, 16'sd32767);
      push_word(CMD_SEARCH, 32'h0, -16'sd32768);
      push_word(CMD_SEARCH, 32'h0, 16'sd0);
      push_word(CMD_NOP, 32'hDEADBEEF, 16'sd5);
      push_word(CMD_REMOVE, 32'h12345678, 16'sd0);
      push_word(CMD_REMOVE, tag_pool[3], 16'sd0);
      push_word(CMD_INSERT, tag_pool[0], 16'sd100);
      push_word(CMD_INSERT, tag_pool[4], 16'sd7);
      push_word(CMD_SEARCH, 32'h0, 16'sd1);

      // length shrunk in the middle of a stream
      push_len(10'd3);
      push_word(CMD_SEARCH, 32'h0, 16'sd9);
      push_word(CMD_INSERT, 32'h0, -16'sd4);
      push_len(10'd1);
      push_word(CMD_INSERT, tag_pool[5], 16'sd2);
      // out-of-range length, then a longer search against short entries
      push_len(10'd1023);
      push_len(10'd2);
      push_word(CMD_SEARCH, 32'h0, 16'sd2);
      push_word(CMD_SEARCH, 32'h0, 16'sd3);

      // random phases over several lengths
      for (int p = 0; random_words < 1400; p++) begin
         push_len(10'(lens[p % 8]));
         phase_words = random_words;
         while (random_words - phase_words < 50) begin
            r = $urandom_range(99);
            if (r < 5)
               push_word(CMD_NOP, $urandom, shortint'($urandom));
            else if (r < 10)
               push_word($urandom_range(1) ? CMD_SEARCH : CMD_INSERT, $urandom,
                         shortint'($urandom));
            else if (r < 45)
               push_stream(CMD_INSERT, tag_pool[$urandom_range(73)]);
            else if (r < 75)
               push_stream(CMD_SEARCH, $urandom);
            else
               push_word(CMD_REMOVE,
                         $urandom_range(4) ? tag_pool[$urandom_range(95)] : $urandom,
                         shortint'($urandom));
         end
      end

      reset <= 1'b1;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      while (word_queue.size() != 0 || start || match_queue.size() != 0)
         @(posedge clock);
      repeat (200) @(posedge clock);
      if (match_queue.size() != 0) failures++;
      if (failures == 0) $display("tb: success");
      else $display("tb: failure");
      $finish;
   end

endmodule
